[hdl/tsw_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and helpers for the trilinear stencil weight block.
package tsw_pkg;

	localparam int CELLS_X_DEF = 8;
	localparam int CELLS_Y_DEF = 8;
	localparam int CELLS_Z_DEF = 8;

	localparam int POS_W  = 12;
	localparam int FRAC_W = 8;
	localparam int LIM_W  = 15;
	localparam int IDX_W  = 5;
	localparam int FLR_W  = POS_W - FRAC_W;
	localparam int FAC_W  = FRAC_W + 1;
	localparam int PAIR_W = 17;
	localparam int PROD_W = 25;
	localparam int SUM_W  = 25;
	localparam int WT_W   = 17;
	localparam int NUM_W  = PROD_W + 16;
	localparam int QBITS  = 17;

	localparam logic [WT_W-1:0] WEIGHT_ONE = WT_W'(65536);

	typedef struct packed {
		logic [2:0]       corner;
		logic [IDX_W-1:0] ci;
		logic [IDX_W-1:0] cj;
		logic [IDX_W-1:0] ck;
		logic             fb;
		logic             last;
	} tsw_meta_t;

	typedef struct packed {
		logic [7:0]                  mask;
		logic                        fb;
		logic [SUM_W-1:0]            sum;
		logic [7:0][PROD_W-1:0]      prod;
		logic [2:0][IDX_W-1:0]       lo;
		logic [2:0][FLR_W-1:0]       flr;
	} tsw_front_t;

	// Entry n of the emission order visits corner {n[0], n[1], n[2]}.
	function automatic logic [2:0] corner_of(input logic [2:0] n);
		return {n[0], n[1], n[2]};
	endfunction

	function automatic logic [POS_W-1:0] clamp_pos(input logic [POS_W-1:0] p,
		input logic [LIM_W-1:0] lim);
		logic [LIM_W-1:0] pz;
		pz = {{(LIM_W-POS_W){1'b0}}, p};
		return (pz > lim) ? lim[POS_W-1:0] : p;
	endfunction

endpackage

[hdl/tsw_front.sv]
`timescale 1ns / 1ps
// Five-stage front pipeline: clamp and split, axis factors, corner products, weight sum.
module tsw_front import tsw_pkg::*; #(
	parameter int CELLS_X = CELLS_X_DEF,
	parameter int CELLS_Y = CELLS_Y_DEF,
	parameter int CELLS_Z = CELLS_Z_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic [POS_W-1:0] pos_i,
	input  logic [POS_W-1:0] pos_j,
	input  logic [POS_W-1:0] pos_k,
	input  logic [7:0]       mask,
	output logic             out_valid,
	output tsw_front_t       out_data
);

	localparam logic [LIM_W-1:0] LIM_X = LIM_W'(CELLS_X * (2 ** FRAC_W));
	localparam logic [LIM_W-1:0] LIM_Y = LIM_W'(CELLS_Y * (2 ** FRAC_W));
	localparam logic [LIM_W-1:0] LIM_Z = LIM_W'(CELLS_Z * (2 ** FRAC_W));
	localparam logic [POS_W-1:0] HALF = POS_W'(2 ** (FRAC_W - 1));

	logic [2:0][POS_W-1:0] pc;
	logic [2:0][POS_W-1:0] pd;
	logic [2:0][FRAC_W-1:0] w_c;
	logic [2:0][IDX_W-1:0] lo_c;

	logic                   v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [2:0][FRAC_W-1:0] w_s1;
	logic [2:0][IDX_W-1:0]  lo_s1, lo_s2, lo_s3, lo_s4, lo_s5;
	logic [2:0][FLR_W-1:0]  flr_s1, flr_s2, flr_s3, flr_s4, flr_s5;
	logic [7:0]             mask_s1, mask_s2, mask_s3, mask_s4, mask_s5;
	logic [3:0][PAIR_W-1:0] pair_s2;
	logic [1:0][FAC_W-1:0]  fz_s2;
	logic [7:0][PROD_W-1:0] prod_s3, prod_s4, prod_s5;
	logic [3:0][SUM_W-1:0]  psum_s4;
	logic [SUM_W-1:0]       sum_s5;
	logic [1:0][FAC_W-1:0]  fx, fy;

	always_comb begin
		pc[0] = clamp_pos(pos_i, LIM_X);
		pc[1] = clamp_pos(pos_j, LIM_Y);
		pc[2] = clamp_pos(pos_k, LIM_Z);
		for (int a = 0; a < 3; a++) begin
			pd[a] = pc[a] - HALF;
			if (pc[a] < HALF) begin
				lo_c[a] = '1;
				w_c[a] = pc[a][FRAC_W-1:0] + HALF[FRAC_W-1:0];
			end else begin
				lo_c[a] = IDX_W'(pd[a][POS_W-1:FRAC_W]);
				w_c[a] = pd[a][FRAC_W-1:0];
			end
		end
	end

	always_comb begin
		fx[0] = FAC_W'(2 ** FRAC_W) - {1'b0, w_s1[0]};
		fx[1] = {1'b0, w_s1[0]};
		fy[0] = FAC_W'(2 ** FRAC_W) - {1'b0, w_s1[1]};
		fy[1] = {1'b0, w_s1[1]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		for (int a = 0; a < 3; a++) begin
			w_s1[a] <= w_c[a];
			lo_s1[a] <= lo_c[a];
			flr_s1[a] <= pc[a][POS_W-1:FRAC_W];
		end
		mask_s1 <= mask;

		for (int b = 0; b < 4; b++) begin
			pair_s2[b] <= PAIR_W'(fx[b % 2] * fy[b / 2]);
		end
		fz_s2[0] <= FAC_W'(2 ** FRAC_W) - {1'b0, w_s1[2]};
		fz_s2[1] <= {1'b0, w_s1[2]};
		lo_s2 <= lo_s1;
		flr_s2 <= flr_s1;
		mask_s2 <= mask_s1;

		for (int c = 0; c < 8; c++) begin
			prod_s3[c] <= PROD_W'(pair_s2[c % 4] * fz_s2[c / 4]);
		end
		lo_s3 <= lo_s2;
		flr_s3 <= flr_s2;
		mask_s3 <= mask_s2;

		for (int m = 0; m < 4; m++) begin
			psum_s4[m] <= (mask_s3[2*m] ? prod_s3[2*m] : '0) +
				(mask_s3[2*m+1] ? prod_s3[2*m+1] : '0);
		end
		prod_s4 <= prod_s3;
		lo_s4 <= lo_s3;
		flr_s4 <= flr_s3;
		mask_s4 <= mask_s3;

		sum_s5 <= psum_s4[0] + psum_s4[1] + psum_s4[2] + psum_s4[3];
		prod_s5 <= prod_s4;
		lo_s5 <= lo_s4;
		flr_s5 <= flr_s4;
		mask_s5 <= mask_s4;
	end

	always_comb begin
		out_valid = v_s5;
		out_data.mask = mask_s5;
		out_data.fb = (sum_s5 == '0);
		out_data.sum = sum_s5;
		out_data.prod = prod_s5;
		out_data.lo = lo_s5;
		out_data.flr = flr_s5;
	end

endmodule

[hdl/tsw_div.sv]
`timescale 1ns / 1ps
// Pipelined restoring divider that normalizes one stencil weight per cycle.
module tsw_div import tsw_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  tsw_meta_t        in_meta,
	input  logic [NUM_W-1:0] num,
	input  logic [SUM_W-1:0] den,
	output logic             out_valid,
	output tsw_meta_t        out_meta,
	output logic [QBITS-1:0] quot
);

	logic [QBITS:0]               v_s;
	tsw_meta_t                    meta_s [0:QBITS];
	logic [SUM_W-1:0]             rem_s  [0:QBITS];
	logic [QBITS-1:0]             nlo_s  [0:QBITS];
	logic [SUM_W-1:0]             den_s  [0:QBITS];
	logic [QBITS-1:0]             q_s    [0:QBITS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else begin
			v_s <= {v_s[QBITS-1:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		meta_s[0] <= in_meta;
		rem_s[0] <= SUM_W'(num[NUM_W-1:QBITS]);
		nlo_s[0] <= num[QBITS-1:0];
		den_s[0] <= den;
		q_s[0] <= '0;
	end

	for (genvar b = 0; b < QBITS; b++) begin : g_step
		logic [SUM_W:0] t;
		logic           ge;
		always_comb begin
			t = {rem_s[b], nlo_s[b][QBITS-1-b]};
			ge = (t >= {1'b0, den_s[b]});
		end
		always_ff @(posedge clk) begin
			meta_s[b+1] <= meta_s[b];
			rem_s[b+1] <= ge ? SUM_W'(t - {1'b0, den_s[b]}) : SUM_W'(t);
			nlo_s[b+1] <= nlo_s[b];
			den_s[b+1] <= den_s[b];
			q_s[b+1] <= {q_s[b][QBITS-2:0], ge};
		end
	end

	assign out_valid = v_s[QBITS];
	assign out_meta = meta_s[QBITS];
	assign quot = q_s[QBITS];

endmodule

[hdl/trilinear_stencil_weights.sv]
`timescale 1ns / 1ps
// The first entry strobes after the front, serializer, divider and output registers.
// Later entries of the same point follow in consecutive cycles, one to eight per point.
// Busy rises after each accepted transaction; start is ignored while busy is high.
// The 18-stage divider and 5-stage front pipeline both accept an entry every cycle.
// Reset clears all valid bits and the busy counter; the receiver cannot stall results.
module trilinear_stencil_weights import tsw_pkg::*; #(
	parameter int CELLS_X = CELLS_X_DEF,
	parameter int CELLS_Y = CELLS_Y_DEF,
	parameter int CELLS_Z = CELLS_Z_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic [POS_W-1:0]        pos_i,
	input  logic [POS_W-1:0]        pos_j,
	input  logic [POS_W-1:0]        pos_k,
	input  logic [7:0]              cell_present,
	output logic                    strobe,
	output logic [2:0]              corner,
	output logic signed [IDX_W-1:0] cell_i,
	output logic signed [IDX_W-1:0] cell_j,
	output logic signed [IDX_W-1:0] cell_k,
	output logic [WT_W-1:0]         weight,
	output logic                    fallback,
	output logic                    last
);

	logic [2:0]       thr_q;
	logic             accept;
	logic             fr_valid;
	tsw_front_t       fr_data;

	logic [7:0]             rem_q;
	logic                   fb_q;
	logic [SUM_W-1:0]       sum_q;
	logic [7:0][PROD_W-1:0] prod_q;
	logic [2:0][IDX_W-1:0]  lo_q;
	logic [2:0][FLR_W-1:0]  flr_q;

	logic [7:0]       sel;
	logic [2:0]       n_sel;
	logic [2:0]       c_sel;
	logic             iss_v;
	tsw_meta_t        iss_meta;
	logic [NUM_W-1:0] iss_num;
	logic [SUM_W-1:0] iss_den;

	logic             dv_valid;
	tsw_meta_t        dv_meta;
	logic [QBITS-1:0] dv_quot;

	assign accept = start && !busy;
	assign busy = (thr_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= '0;
		end else if (accept) begin
			thr_q <= '1;
		end else if (thr_q != '0) begin
			thr_q <= thr_q - 3'd1;
		end
	end

	tsw_front #(
		.CELLS_X(CELLS_X),
		.CELLS_Y(CELLS_Y),
		.CELLS_Z(CELLS_Z)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(accept),
		.pos_i(pos_i),
		.pos_j(pos_j),
		.pos_k(pos_k),
		.mask(cell_present),
		.out_valid(fr_valid),
		.out_data(fr_data)
	);

	always_comb begin
		sel = rem_q & (~rem_q + 8'd1);
		n_sel = '0;
		for (int n = 0; n < 8; n++) begin
			if (sel[n]) begin
				n_sel = 3'(n);
			end
		end
		c_sel = corner_of(n_sel);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
		end else if (fr_valid) begin
			for (int n = 0; n < 8; n++) begin
				rem_q[n] <= fr_data.fb ? (n == 0) : fr_data.mask[corner_of(3'(n))];
			end
		end else begin
			rem_q <= rem_q & ~sel;
		end
	end

	always_ff @(posedge clk) begin
		if (fr_valid) begin
			fb_q <= fr_data.fb;
			sum_q <= fr_data.sum;
			prod_q <= fr_data.prod;
			lo_q <= fr_data.lo;
			flr_q <= fr_data.flr;
		end
	end

	always_comb begin
		iss_v = (rem_q != '0);
		iss_meta.fb = fb_q;
		iss_meta.last = ((rem_q & ~sel) == '0);
		if (fb_q) begin
			iss_meta.corner = '0;
			iss_meta.ci = IDX_W'(flr_q[0]);
			iss_meta.cj = IDX_W'(flr_q[1]);
			iss_meta.ck = IDX_W'(flr_q[2]);
			iss_num = '0;
			iss_den = SUM_W'(1);
		end else begin
			iss_meta.corner = c_sel;
			iss_meta.ci = lo_q[0] + IDX_W'(c_sel[0]);
			iss_meta.cj = lo_q[1] + IDX_W'(c_sel[1]);
			iss_meta.ck = lo_q[2] + IDX_W'(c_sel[2]);
			iss_num = {prod_q[c_sel], 16'b0} + NUM_W'(sum_q >> 1);
			iss_den = sum_q;
		end
	end

	tsw_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(iss_v),
		.in_meta(iss_meta),
		.num(iss_num),
		.den(iss_den),
		.out_valid(dv_valid),
		.out_meta(dv_meta),
		.quot(dv_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe <= 1'b0;
		end else begin
			strobe <= dv_valid;
		end
	end

	always_ff @(posedge clk) begin
		corner <= dv_meta.corner;
		cell_i <= $signed(dv_meta.ci);
		cell_j <= $signed(dv_meta.cj);
		cell_k <= $signed(dv_meta.ck);
		weight <= dv_meta.fb ? WEIGHT_ONE : dv_quot;
		fallback <= dv_meta.fb;
		last <= dv_meta.last;
	end

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("busy did not rise after an accepted transaction");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		fr_valid |-> $countones(rem_q) <= 1)
		else $error("serializer reloaded with more than one entry pending");

	a_fallback_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && fallback |-> last)
		else $error("fallback entry not flagged last");

	a_weight_range: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> weight <= WEIGHT_ONE)
		else $error("weight exceeds one");

endmodule

[sim/tb_trilinear_stencil_weights.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the trilinear stencil weight block with a scoreboard class.

typedef struct packed {
	logic [2:0]  corner;
	logic [4:0]  ci;
	logic [4:0]  cj;
	logic [4:0]  ck;
	logic [16:0] weight;
	logic        fb;
	logic        last;
} entry_t;

class stencil_scoreboard;
	entry_t pending[$];
	int errors;

	function new();
		errors = 0;
	endfunction

	function void split(input logic [11:0] p, output logic [4:0] lower,
		output logic [8:0] w);
		if (p < 12'd128) begin
			lower = 5'h1f;
			w = 9'(p + 12'd128);
		end else begin
			lower = 5'((p - 12'd128) >> 8);
			w = 9'((p - 12'd128) & 12'hff);
		end
	endfunction

	function void note_point(input logic [11:0] pi, pj, pk, input logic [7:0] mask);
		logic [11:0] p[3];
		logic [4:0] lo[3];
		logic [8:0] w[3];
		logic [8:0] f[3][2];
		logic [63:0] prod[8];
		logic [63:0] sum;
		logic [63:0] wt;
		int count, n, c;
		entry_t e;
		p[0] = pi > 12'(8 * 256) ? 12'(8 * 256) : pi;
		p[1] = pj > 12'(8 * 256) ? 12'(8 * 256) : pj;
		p[2] = pk > 12'(8 * 256) ? 12'(8 * 256) : pk;
		sum = 0;
		count = 0;
		n = 0;
		for (int a = 0; a < 3; a++) begin
			split(p[a], lo[a], w[a]);
			f[a][0] = 9'd256 - w[a];
			f[a][1] = w[a];
		end
		for (int a = 0; a < 8; a++) begin
			prod[a] = 64'(f[0][a & 1]) * 64'(f[1][(a >> 1) & 1]) * 64'(f[2][(a >> 2) & 1]);
			if (mask[a]) begin
				sum += prod[a];
				count++;
			end
		end
		if (count == 0 || sum == 0) begin
			e = '{3'd0, 5'(p[0] >> 8), 5'(p[1] >> 8), 5'(p[2] >> 8), 17'd65536, 1'b1, 1'b1};
			pending.push_back(e);
			return;
		end
		for (int i = 0; i < 2; i++)
			for (int j = 0; j < 2; j++)
				for (int k = 0; k < 2; k++) begin
					c = i + 2 * j + 4 * k;
					if (mask[c]) begin
						if (count == 8)
							wt = (prod[c] + 64'd128) >> 8;
						else
							wt = ((prod[c] << 16) + (sum >> 1)) / sum;
						n++;
						e = '{3'(c), 5'(lo[0] + 5'(i)), 5'(lo[1] + 5'(j)), 5'(lo[2] + 5'(k)),
							17'(wt), 1'b0, n == count};
						pending.push_back(e);
					end
				end
	endfunction

	function void check_entry(input entry_t got);
		entry_t want;
		if (pending.size() == 0) begin
			$display("%0t: unexpected stencil entry corner=%0d weight=%0d", $time,
				got.corner, got.weight);
			errors++;
			return;
		end
		want = pending.pop_front();
		if (got !== want) begin
			$display("%0t: mismatch expected c=%0d i=%0d j=%0d k=%0d w=%0d fb=%0d l=%0d",
				$time, want.corner, want.ci, want.cj, want.ck, want.weight, want.fb, want.last);
			$display("%0t:          actual   c=%0d i=%0d j=%0d k=%0d w=%0d fb=%0d l=%0d",
				$time, got.corner, got.ci, got.cj, got.ck, got.weight, got.fb, got.last);
			errors++;
		end
	endfunction
endclass

module tb_trilinear_stencil_weights import tsw_pkg::*;;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [POS_W-1:0] pos_i = '0, pos_j = '0, pos_k = '0;
	logic [7:0] cell_present = '0;
	logic busy, strobe, fallback, last;
	logic [2:0] corner;
	logic signed [IDX_W-1:0] cell_i, cell_j, cell_k;
	logic [WT_W-1:0] weight;

	stencil_scoreboard board = new();
	int idle_cycles = 0;
	bit timed_out = 0;

	trilinear_stencil_weights dut (.*);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		entry_t got;
		if (arst_n && strobe) begin
			got = '{corner, cell_i, cell_j, cell_k, weight, fallback, last};
			board.check_entry(got);
		end
		if (arst_n && (strobe || (start && !busy)))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 2000 && !timed_out) begin
			timed_out = 1;
			$display("trilinear_stencil_weights verification failed");
			$finish;
		end
	end

	task automatic send_point(input logic [11:0] pi, pj, pk, input logic [7:0] mask);
		pos_i <= pi;
		pos_j <= pj;
		pos_k <= pk;
		cell_present <= mask;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		board.note_point(pi, pj, pk, mask);
	endtask

	task automatic random_gap();
		int g;
		g = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) :
			(($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 3));
		if (g > 0)
			start <= 1'b0;
		repeat (g) @(posedge clk);
	endtask

	function automatic logic [11:0] rand_pos();
		case ($urandom_range(0, 5))
			0: return 12'($urandom_range(0, 255));
			1: return 12'($urandom_range(1920, 2048));
			2: return 12'($urandom);
			default: return 12'($urandom_range(0, 2048));
		endcase
	endfunction

	initial begin
		logic [7:0] m;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_point(12'd0, 12'd0, 12'd0, 8'hff);
		send_point(12'd2048, 12'd2048, 12'd2048, 8'hff);
		send_point(12'hfff, 12'hfff, 12'hfff, 8'hff);
		send_point(12'd128, 12'd384, 12'd127, 8'hff);
		send_point(12'd300, 12'd500, 12'd700, 8'h00);
		send_point(12'd128, 12'd128, 12'd128, 8'hfe);
		send_point(12'd1000, 12'd900, 12'd1100, 8'h5a);
		send_point(12'd2048, 12'd0, 12'd1024, 8'h01);
		send_point(12'd384, 12'd384, 12'd384, 8'h80);
		send_point(12'h555, 12'haaa, 12'h7ff, 8'h3c);
		send_point(12'haaa, 12'h555, 12'h800, 8'hc3);
		send_point(12'd200, 12'd1800, 12'd64, 8'h10);
		for (int n = 0; n < 380; n++) begin
			random_gap();
			case ($urandom_range(0, 4))
				0: m = 8'hff;
				1: m = 8'h00;
				2: m = 8'(1 << $urandom_range(0, 7));
				default: m = 8'($urandom);
			endcase
			send_point(rand_pos(), rand_pos(), rand_pos(), m);
		end
		start <= 1'b0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (board.errors == 0)
			$display("trilinear_stencil_weights verification clean");
		else
			$display("trilinear_stencil_weights verification failed");
		$finish;
	end
endmodule
